### src/multilevel_ready_queue_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Multilevel ready-queue scheduler assertion macros
// Shared assertion forms; the module that uses them provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_READY_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_READY_QUEUE_SCHEDULER_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define MLRQ_ASSERT_ALW(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mlrq: invariant violated");

// Check that a condition implies another in the same cycle
`define MLRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlrq: same-cycle implication violated");

// Check that a condition implies another in the next cycle
`define MLRQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlrq: next-cycle implication violated");

`endif

### src/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel ready-queue scheduler package
// Widths, default sizes, request and status codes and the compare unit result
// shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlrq_pkg;

    // Default sizes
    localparam int LEVELS_DEF    = 5;
    localparam int MAX_TASKS_DEF = 1024;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int ID_W   = 64;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int LVL_W  = 4;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE      = 2'd3;

    // Outcome of the shared compare unit
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

`default_nettype wire

### src/multilevel_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel ready-queue scheduler
// One FIFO ready queue per priority level with round-robin run counts; add,
// pick and remove requests served one at a time by a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one request word, works on it alone, then offers one result
// word; a finished result waits in the output register while the next request
// is taken. An add goes through the link and node steps, or straight to the
// output when it is rejected for a bad level or a full pool. A pick scans the
// levels one by one, at most two passes, then pops the head of the chosen
// level; a remove compares the nodes of its level in list order up to a match
// or the last node (a bad or empty level, and the unused request kind, go
// straight to the output). The output step waits while the output register
// still holds an unread result. The scan and the list walk share one compare
// unit and one read port of the node memory, one level or one node per cycle.
// The free-slot ring needs no clearing pass after reset: a fill count marks
// which ring entries have been written, so the block is ready out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multilevel_ready_queue_scheduler_macros.svh"

module multilevel_ready_queue_scheduler #(
    parameter int LEVELS    = mlrq_pkg::LEVELS_DEF,
    parameter int MAX_TASKS = mlrq_pkg::MAX_TASKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // task_id [63:0], priority_req [71:64]
    input  wire logic [1:0]  s_tuser,   // req_type [1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // picked_id [63:0], picked_level [67:64], zero
    output logic [1:0]       m_tuser    // status [1:0]
);

    localparam int SW     = $clog2(MAX_TASKS);
    localparam int CW     = $clog2(MAX_TASKS + 1);
    localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ID_W   = mlrq_pkg::ID_W;
    localparam int LVL_W  = mlrq_pkg::LVL_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISP     = 3'd1;
    localparam logic [2:0] S_ADD_LINK = 3'd2;
    localparam logic [2:0] S_ADD_NODE = 3'd3;
    localparam logic [2:0] S_PICK_SCAN = 3'd4;
    localparam logic [2:0] S_PICK_POP = 3'd5;
    localparam logic [2:0] S_REM_CMP  = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        req_type_reg, req_type_next;
    logic [ID_W-1:0]   req_id_reg, req_id_next;
    logic [7:0]        req_lvl_reg, req_lvl_next;
    logic [LIDX_W-1:0] scan_reg, scan_next;
    logic              pass_reg, pass_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [SW-1:0]     prev_reg, prev_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [LVL_W-1:0]  res_lvl_reg, res_lvl_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    logic [LVL_W-1:0]  m_lvl_reg, m_lvl_next;

    logic [SW-1:0] level_head_reg  [LEVELS];
    logic [SW-1:0] level_head_next [LEVELS];
    logic [SW-1:0] level_tail_reg  [LEVELS];
    logic [SW-1:0] level_tail_next [LEVELS];
    logic [CW-1:0] level_count_reg [LEVELS];
    logic [CW-1:0] level_count_next[LEVELS];
    logic [CW-1:0] run_count_reg   [LEVELS];
    logic [CW-1:0] run_count_next  [LEVELS];

    logic [LIDX_W-1:0] lidx;
    logic              lvl_ok;
    logic              last_node;

    // node memory port
    logic            node_rd_en;
    logic [SW-1:0]   node_rd_addr;
    logic [ID_W-1:0] node_id_q;
    logic [SW-1:0]   node_next_q;
    logic            node_id_we;
    logic            node_next_we;
    logic [SW-1:0]   node_wr_addr;
    logic [ID_W-1:0] node_id_wdata;
    logic [SW-1:0]   node_next_wdata;

    // free ring port
    logic          ring_fetch;
    logic          ring_take;
    logic          ring_push;
    logic [SW-1:0] ring_push_slot;
    logic [SW-1:0] ring_slot;
    logic          ring_empty;

    // shared compare unit
    logic [ID_W-1:0]    cmp_a;
    logic [ID_W-1:0]    cmp_b;
    mlrq_pkg::cmp_res_t cmp_res;

    mlrq_node_mem #(
        .MAX_TASKS (MAX_TASKS)
    ) u_node_mem (
        .clk        (clk),
        .rd_en      (node_rd_en),
        .rd_addr    (node_rd_addr),
        .id_q       (node_id_q),
        .next_q     (node_next_q),
        .id_we      (node_id_we),
        .next_we    (node_next_we),
        .wr_addr    (node_wr_addr),
        .id_wdata   (node_id_wdata),
        .next_wdata (node_next_wdata)
    );

    mlrq_free_ring #(
        .MAX_TASKS (MAX_TASKS)
    ) u_free_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .fetch     (ring_fetch),
        .take      (ring_take),
        .push      (ring_push),
        .push_slot (ring_push_slot),
        .slot      (ring_slot),
        .empty     (ring_empty)
    );

    mlrq_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // Select the level under work: scan index for pick, request level otherwise
    assign lidx = ((state_reg == S_PICK_SCAN) || (state_reg == S_PICK_POP)) ?
                  scan_reg : req_lvl_reg[LIDX_W-1:0];
    assign lvl_ok    = ({24'd0, req_lvl_reg} < 32'(LEVELS));
    assign last_node = ((k_reg + CW'(1)) == level_count_reg[lidx]);

    // Feed the compare unit: run count against queue length in the scan,
    // stored ID against requested ID in the walk
    always_comb
    begin
        if (state_reg == S_PICK_SCAN)
        begin
            cmp_a = ID_W'(run_count_reg[lidx]);
            cmp_b = ID_W'(level_count_reg[lidx]);
        end
        else
        begin
            cmp_a = node_id_q;
            cmp_b = req_id_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        req_id_next     = req_id_reg;
        req_lvl_next    = req_lvl_reg;
        scan_next       = scan_reg;
        pass_next       = pass_reg;
        k_next          = k_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_lvl_next    = res_lvl_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_lvl_next      = m_lvl_reg;
        level_head_next  = level_head_reg;
        level_tail_next  = level_tail_reg;
        level_count_next = level_count_reg;
        run_count_next   = run_count_reg;

        node_rd_en      = 1'b0;
        node_rd_addr    = level_head_reg[lidx];
        node_id_we      = 1'b0;
        node_next_we    = 1'b0;
        node_wr_addr    = ring_slot;
        node_id_wdata   = req_id_reg;
        node_next_wdata = '0;
        ring_fetch      = 1'b0;
        ring_take       = 1'b0;
        ring_push       = 1'b0;
        ring_push_slot  = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Take the request word and clear the result payload
                if (s_tvalid)
                begin
                    req_type_next = s_tuser;
                    req_id_next   = s_tdata[63:0];
                    req_lvl_next  = s_tdata[71:64];
                    res_id_next   = '0;
                    res_lvl_next  = '0;
                    state_next    = S_DISP;
                end
            end

            S_DISP:
            begin
                case (req_type_reg)
                    mlrq_pkg::REQ_ADD:
                    begin
                        if (!lvl_ok)
                        begin
                            res_status_next = mlrq_pkg::ST_BAD_LEVEL;
                            state_next      = S_OUT;
                        end
                        else if (ring_empty)
                        begin
                            res_status_next = mlrq_pkg::ST_NONE;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            ring_fetch = 1'b1;
                            state_next = S_ADD_LINK;
                        end
                    end
                    mlrq_pkg::REQ_PICK:
                    begin
                        scan_next  = '0;
                        pass_next  = 1'b0;
                        state_next = S_PICK_SCAN;
                    end
                    mlrq_pkg::REQ_REMOVE:
                    begin
                        if (!lvl_ok)
                        begin
                            res_status_next = mlrq_pkg::ST_BAD_LEVEL;
                            state_next      = S_OUT;
                        end
                        else if (level_count_reg[lidx] == '0)
                        begin
                            res_status_next = mlrq_pkg::ST_NOT_FOUND;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            node_rd_en   = 1'b1;
                            node_rd_addr = level_head_reg[lidx];
                            cur_next     = level_head_reg[lidx];
                            prev_next    = '0;
                            k_next       = '0;
                            state_next   = S_REM_CMP;
                        end
                    end
                    default:
                    begin
                        res_status_next = mlrq_pkg::ST_NONE;
                        state_next      = S_OUT;
                    end
                endcase
            end

            S_ADD_LINK:
            begin
                // Chain the old tail to the new slot
                if (level_count_reg[lidx] != '0)
                begin
                    node_next_we    = 1'b1;
                    node_wr_addr    = level_tail_reg[lidx];
                    node_next_wdata = ring_slot;
                end
                state_next = S_ADD_NODE;
            end

            S_ADD_NODE:
            begin
                // Fill the new node and append it
                node_id_we      = 1'b1;
                node_next_we    = 1'b1;
                node_wr_addr    = ring_slot;
                node_id_wdata   = req_id_reg;
                node_next_wdata = '0;
                ring_take       = 1'b1;
                if (level_count_reg[lidx] == '0)
                begin
                    level_head_next[lidx] = ring_slot;
                end
                level_tail_next[lidx]  = ring_slot;
                level_count_next[lidx] = level_count_reg[lidx] + 1'b1;
                res_status_next        = mlrq_pkg::ST_DONE;
                state_next             = S_OUT;
            end

            S_PICK_SCAN:
            begin
                if (cmp_res.lt)
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = level_head_reg[lidx];
                    state_next   = S_PICK_POP;
                end
                else
                begin
                    // Level used its share or is empty: clear its run count and yield
                    run_count_next[lidx] = '0;
                    if (scan_reg == LIDX_W'(LEVELS - 1))
                    begin
                        if (pass_reg)
                        begin
                            res_status_next = mlrq_pkg::ST_NONE;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            pass_next = 1'b1;
                            scan_next = '0;
                        end
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end

            S_PICK_POP:
            begin
                // Drop the head node and release its slot
                res_id_next            = node_id_q;
                res_lvl_next           = LVL_W'(scan_reg);
                res_status_next        = mlrq_pkg::ST_DONE;
                level_head_next[lidx]  = node_next_q;
                level_count_next[lidx] = level_count_reg[lidx] - 1'b1;
                run_count_next[lidx]   = run_count_reg[lidx] + 1'b1;
                ring_push              = 1'b1;
                ring_push_slot         = level_head_reg[lidx];
                state_next             = S_OUT;
            end

            S_REM_CMP:
            begin
                if (cmp_res.eq)
                begin
                    // Unlink the matching node
                    if (k_reg == '0)
                    begin
                        level_head_next[lidx] = node_next_q;
                    end
                    else
                    begin
                        node_next_we    = 1'b1;
                        node_wr_addr    = prev_reg;
                        node_next_wdata = node_next_q;
                    end
                    if (last_node)
                    begin
                        level_tail_next[lidx] = prev_reg;
                    end
                    level_count_next[lidx] = level_count_reg[lidx] - 1'b1;
                    ring_push              = 1'b1;
                    ring_push_slot         = cur_reg;
                    res_id_next            = req_id_reg;
                    res_lvl_next           = LVL_W'(lidx);
                    res_status_next        = mlrq_pkg::ST_DONE;
                    state_next             = S_OUT;
                end
                else if (last_node)
                begin
                    res_status_next = mlrq_pkg::ST_NOT_FOUND;
                    state_next      = S_OUT;
                end
                else
                begin
                    // Advance to the next node in the list
                    prev_next    = cur_reg;
                    cur_next     = node_next_q;
                    k_next       = k_reg + 1'b1;
                    node_rd_en   = 1'b1;
                    node_rd_addr = node_next_q;
                end
            end

            S_OUT:
            begin
                // Hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_id_next     = res_id_reg;
                    m_lvl_next    = res_lvl_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and level tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                level_head_reg[i]  <= '0;
                level_tail_reg[i]  <= '0;
                level_count_reg[i] <= '0;
                run_count_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            level_head_reg  <= level_head_next;
            level_tail_reg  <= level_tail_next;
            level_count_reg <= level_count_next;
            run_count_reg   <= run_count_next;
        end
    end

    // Request, walk and result payload
    always_ff @(posedge clk)
    begin
        req_type_reg   <= req_type_next;
        req_id_reg     <= req_id_next;
        req_lvl_reg    <= req_lvl_next;
        scan_reg       <= scan_next;
        pass_reg       <= pass_next;
        k_reg          <= k_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_lvl_reg    <= res_lvl_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_lvl_reg      <= m_lvl_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_lvl_reg, m_id_reg};

    `MLRQ_ASSERT_IMP(a_fail_zero, m_tvalid && (m_tuser != mlrq_pkg::ST_DONE), m_tdata == '0)
    `MLRQ_ASSERT_IMP(a_walk_bound, state_reg == S_REM_CMP, k_reg < level_count_reg[lidx])
    `MLRQ_ASSERT_IMP(a_pop_nonempty, state_reg == S_PICK_POP, level_count_reg[lidx] != '0)
    `MLRQ_ASSERT_NXT(a_accept_disp, s_tvalid && s_tready, state_reg == S_DISP)

endmodule

`default_nettype wire

### src/mlrq_node_mem.sv
// ----------------------------------------------------------------------------
// Queue node memory
// Task ID and next-link per pool slot, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlrq_node_mem #(
    parameter int MAX_TASKS = mlrq_pkg::MAX_TASKS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(MAX_TASKS)-1:0] rd_addr,
    output logic [mlrq_pkg::ID_W-1:0]       id_q,
    output logic [$clog2(MAX_TASKS)-1:0]    next_q,
    input  wire logic                       id_we,
    input  wire logic                       next_we,
    input  wire logic [$clog2(MAX_TASKS)-1:0] wr_addr,
    input  wire logic [mlrq_pkg::ID_W-1:0]  id_wdata,
    input  wire logic [$clog2(MAX_TASKS)-1:0] next_wdata
);

    localparam int SW = $clog2(MAX_TASKS);

    logic [mlrq_pkg::ID_W-1:0] id_mem   [MAX_TASKS];
    logic [SW-1:0]             next_mem [MAX_TASKS];
    logic [mlrq_pkg::ID_W-1:0] id_q_reg;
    logic [SW-1:0]             next_q_reg;

    // Write the ID and link arrays
    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[wr_addr] <= id_wdata;
        end
        if (next_we)
        begin
            next_mem[wr_addr] <= next_wdata;
        end
    end

    // Read one node into the output registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            id_q_reg   <= id_mem[rd_addr];
            next_q_reg <= next_mem[rd_addr];
        end
    end

    assign id_q   = id_q_reg;
    assign next_q = next_q_reg;

endmodule

`default_nettype wire

### src/mlrq_free_ring.sv
// ----------------------------------------------------------------------------
// Free slot ring
// Ring of free pool slots; entries never written since reset read as their
// own index, tracked by a saturating fill count.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multilevel_ready_queue_scheduler_macros.svh"

module mlrq_free_ring #(
    parameter int MAX_TASKS = mlrq_pkg::MAX_TASKS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fetch,
    input  wire logic                         take,
    input  wire logic                         push,
    input  wire logic [$clog2(MAX_TASKS)-1:0] push_slot,
    output logic [$clog2(MAX_TASKS)-1:0]      slot,
    output logic                              empty
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [SW-1:0] ring_mem [MAX_TASKS];
    logic [SW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [SW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [CW-1:0] fill_reg,   fill_next;
    logic [SW-1:0] mem_q_reg;
    logic [SW-1:0] idx_reg;
    logic          init_reg;
    logic          do_push;

    assign do_push = push && (cnt_reg < CW'(MAX_TASKS));

    // Advance pointers, free count and fill count
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        fill_next   = fill_reg;
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == SW'(MAX_TASKS - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == SW'(MAX_TASKS - 1)) ? '0 : wr_ptr_reg + 1'b1;
            cnt_next    = cnt_next + 1'b1;
            if (fill_reg != CW'(MAX_TASKS))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= CW'(MAX_TASKS);
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
            fill_reg   <= fill_next;
        end
    end

    // Write a released slot behind the read pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ring_mem[wr_ptr_reg] <= push_slot;
        end
    end

    // Read the slot at the read pointer; unwritten entries hold their index
    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            mem_q_reg <= ring_mem[rd_ptr_reg];
            idx_reg   <= rd_ptr_reg;
            init_reg  <= (CW'(rd_ptr_reg) >= fill_reg);
        end
    end

    assign slot  = init_reg ? idx_reg : mem_q_reg;
    assign empty = (cnt_reg == '0);

    `MLRQ_ASSERT_ALW(a_cnt_bound, cnt_reg <= CW'(MAX_TASKS))
    `MLRQ_ASSERT_IMP(a_take_nonempty, take, cnt_reg != '0)

endmodule

`default_nettype wire

### src/mlrq_cmp.sv
// ----------------------------------------------------------------------------
// Shared compare unit
// Equality and unsigned less-than on one operand pair, reused by every walk.
// ----------------------------------------------------------------------------
`default_nettype none

module mlrq_cmp (
    input  wire logic [mlrq_pkg::ID_W-1:0] a,
    input  wire logic [mlrq_pkg::ID_W-1:0] b,
    output mlrq_pkg::cmp_res_t             res
);

    // Compare the operand pair
    always_comb
    begin
        res.eq = (a == b);
        res.lt = (a < b);
    end

endmodule

`default_nettype wire
